// File: src/palette_alpha_blend_quantizer_macros.svh
// assertion macros used by the top-level rtl file
`ifndef PALETTE_ALPHA_BLEND_QUANTIZER_MACROS_SVH
`define PALETTE_ALPHA_BLEND_QUANTIZER_MACROS_SVH

`ifndef SYNTHESIS

// condition implies expr in the same cycle
`define PABQ_ASSERT_IMP(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("pabq assertion failed");

// condition implies expr in the next cycle
`define PABQ_ASSERT_NXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("pabq assertion failed");

`else

`define PABQ_ASSERT_IMP(label, clk, rst_n, cond, expr)
`define PABQ_ASSERT_NXT(label, clk, rst_n, cond, expr)

`endif

`endif

// File: src/pabq_pkg.sv
`default_nettype none

package pabq_pkg;

  // palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int DIST_W        = 18;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_IDX_BLEND = 2'd1;
  localparam logic [1:0] OP_RGB_BLEND = 2'd2;

  // tileset modes
  localparam logic [1:0] MODE_OTHER      = 2'd0;
  localparam logic [1:0] MODE_LOW_CYCLE  = 2'd1;
  localparam logic [1:0] MODE_HIGH_CYCLE = 2'd2;

  // blend channel select
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // special index ranges
  localparam logic [IDX_W-1:0] IDX_LOW_FIRST     = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LOW_MODE_FIRST = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_LOW_LAST      = IDX_W'(13);
  localparam logic [IDX_W-1:0] IDX_HIGH_MODE     = IDX_W'(247);
  localparam logic [IDX_W-1:0] IDX_HIGH_FIRST    = IDX_W'(248);
  localparam logic [IDX_W-1:0] IDX_HIGH_LAST     = IDX_W'(254);
  localparam logic [IDX_W-1:0] IDX_LAST          = IDX_W'(PALETTE_DEPTH - 1);

  localparam logic [7:0] ALPHA_ZERO = 8'd0;
  localparam logic [7:0] ALPHA_MAX  = 8'd255;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // classified commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PICK  = 2'd1,
    CMD_IDX   = 2'd2,
    CMD_RGB   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [7:0]       alpha;
    rgb_t             c1;
    rgb_t             c2;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_stat_t;

  // back sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD1   = 8'b0000_0010,
    ST_RD2   = 8'b0000_0100,
    ST_MIX   = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_KEEP  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } bk_state_t;

  // index eligibility under the tileset mode
  function automatic logic eligible(input logic [IDX_W-1:0] idx, input logic [1:0] mode);
    logic ok;
    ok = 1'b1;
    if (idx >= IDX_LOW_FIRST && idx <= IDX_LOW_LAST) begin
      ok = (idx >= IDX_LOW_MODE_FIRST) && (mode == MODE_LOW_CYCLE);
    end else if (idx >= IDX_HIGH_MODE && idx <= IDX_HIGH_LAST) begin
      ok = (idx == IDX_HIGH_MODE) && (mode == MODE_HIGH_CYCLE);
    end
    return ok;
  endfunction

  // indices covered by the colour-cycling keep rule
  function automatic logic cycle_index(input logic [IDX_W-1:0] idx);
    return (idx >= IDX_LOW_FIRST && idx <= IDX_LOW_LAST) ||
           (idx >= IDX_HIGH_FIRST && idx <= IDX_HIGH_LAST);
  endfunction

  // floor((a*c1 + (255-a)*c2) / 255), division by reciprocal trick
  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] c1,
                                      input logic [7:0] c2);
    logic [15:0] s;
    logic [15:0] t;
    logic [7:0]  na;
    na = ALPHA_MAX - a;
    s  = ({8'd0, a} * {8'd0, c1}) + ({8'd0, na} * {8'd0, c2});
    t  = s + 16'd1 + {8'd0, s[15:8]};
    return t[15:8];
  endfunction

  // squared difference of two channels
  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    p = d * d;
    return p[15:0];
  endfunction

endpackage

`default_nettype wire

// File: src/palette_alpha_blend_quantizer.sv
// a palette write or alpha shortcut goes from the front holding stage and the queue
//   straight to the result; a full blend reads its palette operands (index blend only),
//   mixes the three channels, scans the palette and decides; the back takes no new item
//   until its result is loaded; the scan reads the single port one entry per cycle
// reset: synchronous active-low rst_n clears control state, the mode register to 0
//   and every palette written flag at once, so all entries read as black after reset
`default_nettype none
`include "palette_alpha_blend_quantizer_macros.svh"

module palette_alpha_blend_quantizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_first_index,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_second_index,
  input  wire logic [7:0]                  in_first_red,
  input  wire logic [7:0]                  in_first_green,
  input  wire logic [7:0]                  in_first_blue,
  input  wire logic [7:0]                  in_second_red,
  input  wire logic [7:0]                  in_second_green,
  input  wire logic [7:0]                  in_second_blue,
  input  wire logic [7:0]                  in_alpha,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pabq_pkg::IDX_W-1:0]       out_color_index,
  output logic                             out_is_blend,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_tileset_mode
);

  logic              mode_r;
  logic [1:0]        tileset_mode_r;
  pabq_pkg::q_stat_t q_stat;
  logic              push_valid;
  pabq_pkg::item_t   push_item;
  logic              q_valid;
  logic              q_ready;
  pabq_pkg::item_t   q_item;
  logic              back_busy;
  logic              q_pop;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tileset_mode_r <= pabq_pkg::MODE_OTHER;
      mode_r         <= 1'b0;
    end else begin
      mode_r <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        tileset_mode_r <= cfg_tileset_mode;
      end
    end
  end

  // front: accept and classify
  pabq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_first_red    (in_first_red),
    .in_first_green  (in_first_green),
    .in_first_blue   (in_first_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .in_alpha        (in_alpha),
    .q_stat          (q_stat),
    .push_valid      (push_valid),
    .push_item       (push_item)
  );

  // queue between front and back
  pabq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_stat     (q_stat),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // back: palette, blend, scan, result
  pabq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (tileset_mode_r),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_index (out_color_index),
    .out_is_blend    (out_is_blend),
    .busy            (back_busy)
  );

  assign q_pop = q_valid && q_ready;

  // checks
  `PABQ_ASSERT_IMP(a_pop_not_empty, clk, rst_n, q_pop, q_stat.count != '0)
  `PABQ_ASSERT_IMP(a_queue_bound, clk, rst_n, mode_r,
                   q_stat.count <= pabq_pkg::QCNT_W'(pabq_pkg::QUEUE_DEPTH))
  `PABQ_ASSERT_NXT(a_pop_starts_work, clk, rst_n, q_pop, back_busy)

endmodule

`default_nettype wire

// File: src/pabq_front.sv
`default_nettype none

module pabq_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_first_index,
  input  wire logic [pabq_pkg::IDX_W-1:0]  in_second_index,
  input  wire logic [7:0]                  in_first_red,
  input  wire logic [7:0]                  in_first_green,
  input  wire logic [7:0]                  in_first_blue,
  input  wire logic [7:0]                  in_second_red,
  input  wire logic [7:0]                  in_second_green,
  input  wire logic [7:0]                  in_second_blue,
  input  wire logic [7:0]                  in_alpha,
  input  wire pabq_pkg::q_stat_t           q_stat,
  output logic                             push_valid,
  output pabq_pkg::item_t                  push_item
);

  logic            fv_r;
  logic            fv_nxt;
  pabq_pkg::item_t item_r;
  pabq_pkg::item_t item_nxt;
  logic            op_ok;
  logic            moved;
  logic            accept;

  // classify the incoming item
  always_comb begin
    item_nxt     = '0;
    op_ok        = 1'b1;
    item_nxt.c1  = '{r: in_first_red, g: in_first_green, b: in_first_blue};
    item_nxt.c2  = '{r: in_second_red, g: in_second_green, b: in_second_blue};
    item_nxt.alpha = in_alpha;
    item_nxt.idx_b = in_second_index;
    case (in_op)
      pabq_pkg::OP_WRITE: begin
        item_nxt.cmd   = pabq_pkg::CMD_WRITE;
        item_nxt.idx_a = in_entry_index;
      end
      pabq_pkg::OP_IDX_BLEND: begin
        if (in_alpha == pabq_pkg::ALPHA_ZERO) begin
          item_nxt.cmd   = pabq_pkg::CMD_PICK;
          item_nxt.idx_a = in_second_index;
        end else if (in_alpha == pabq_pkg::ALPHA_MAX) begin
          item_nxt.cmd   = pabq_pkg::CMD_PICK;
          item_nxt.idx_a = in_first_index;
        end else begin
          item_nxt.cmd   = pabq_pkg::CMD_IDX;
          item_nxt.idx_a = in_first_index;
        end
      end
      pabq_pkg::OP_RGB_BLEND: begin
        item_nxt.cmd = pabq_pkg::CMD_RGB;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // one holding stage in front of the queue
  assign moved      = fv_r && !q_stat.full;
  assign in_ready   = !fv_r || !q_stat.full;
  assign accept     = in_valid && in_ready;
  assign push_valid = fv_r;
  assign push_item  = item_r;

  always_comb begin
    fv_nxt = fv_r && !moved;
    if (accept && op_ok) begin
      fv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op_ok) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/pabq_queue.sv
`default_nettype none

module pabq_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire pabq_pkg::item_t  push_item,
  output pabq_pkg::q_stat_t     q_stat,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output pabq_pkg::item_t       pop_item
);

  pabq_pkg::item_t                   q_mem [pabq_pkg::QUEUE_DEPTH];
  logic [pabq_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [pabq_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [pabq_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [pabq_pkg::QPTR_W-1:0]       rd_ptr_nxt;
  logic [pabq_pkg::QCNT_W-1:0]       count_r;
  logic [pabq_pkg::QCNT_W-1:0]       count_nxt;
  logic                              full;
  logic                              push;
  logic                              pop;

  assign full      = (count_r == pabq_pkg::QCNT_W'(pabq_pkg::QUEUE_DEPTH));
  assign push      = push_valid && !full;
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = q_mem[rd_ptr_r];
  assign q_stat    = '{count: count_r, full: full};

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: src/pabq_back.sv
`default_nettype none

module pabq_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  mode,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire pabq_pkg::item_t             q_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pabq_pkg::IDX_W-1:0]       out_color_index,
  output logic                             out_is_blend,
  output logic                             busy
);

  pabq_pkg::bk_state_t              state_r;
  pabq_pkg::bk_state_t              state_nxt;
  logic [1:0]                       ch_r;
  logic [1:0]                       ch_nxt;
  logic [pabq_pkg::IDX_W-1:0]       scan_idx_r;
  logic [pabq_pkg::IDX_W-1:0]       scan_idx_nxt;
  logic                             s1_vld_r;
  logic                             s1_vld_nxt;
  logic                             s2_vld_r;
  logic                             s2_vld_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;

  pabq_pkg::rgb_t                   palette_mem [pabq_pkg::PALETTE_DEPTH];
  logic [pabq_pkg::PALETTE_DEPTH-1:0] pal_ok_r;
  pabq_pkg::rgb_t                   rd_data_r;
  logic                             rd_ok_r;
  pabq_pkg::rgb_t                   rd_rgb;
  logic [pabq_pkg::IDX_W-1:0]       raddr;
  logic                             pop;
  logic                             wr_en;

  pabq_pkg::item_t                  cur_r;
  pabq_pkg::rgb_t                   c1_r;
  pabq_pkg::rgb_t                   c2_r;
  pabq_pkg::rgb_t                   mix_r;
  logic [pabq_pkg::IDX_W-1:0]       s1_idx_r;
  logic [pabq_pkg::IDX_W-1:0]       s2_idx_r;
  pabq_pkg::rgb_t                   s2_rgb_r;
  logic [15:0]                      sq_r_r;
  logic [15:0]                      sq_g_r;
  logic [15:0]                      sq_b_r;
  logic [pabq_pkg::DIST_W-1:0]      dist_sum;
  logic [pabq_pkg::DIST_W-1:0]      best_r;
  logic [pabq_pkg::IDX_W-1:0]       pick_r;
  pabq_pkg::rgb_t                   pick_rgb_r;
  logic [pabq_pkg::IDX_W-1:0]       res_r;
  logic                             blend_r;
  logic                             keep;
  logic                             out_load;
  logic [pabq_pkg::IDX_W-1:0]       out_idx_r;
  logic                             out_blend_r;

  assign q_ready = (state_r == pabq_pkg::ST_IDLE);
  assign pop     = q_valid && q_ready;
  assign wr_en   = pop && (q_item.cmd == pabq_pkg::CMD_WRITE);
  assign busy    = (state_r != pabq_pkg::ST_IDLE);

  // palette read address
  always_comb begin
    case (state_r)
      pabq_pkg::ST_IDLE: raddr = q_item.idx_a;
      pabq_pkg::ST_RD1:  raddr = cur_r.idx_b;
      default:           raddr = scan_idx_r;
    endcase
  end

  // palette memory, one port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[q_item.idx_a] <= q_item.c1;
    end
    rd_data_r <= palette_mem[raddr];
  end

  // written flags: an unwritten entry reads as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_ok_r <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        pal_ok_r[q_item.idx_a] <= 1'b1;
      end
      rd_ok_r <= pal_ok_r[raddr];
    end
  end

  assign rd_rgb = rd_ok_r ? rd_data_r : '0;

  // colour-cycling keep rule
  assign keep = (cur_r.cmd == pabq_pkg::CMD_IDX) && pabq_pkg::cycle_index(cur_r.idx_b) &&
                (pick_r != cur_r.idx_b) && (pick_rgb_r == c2_r);

  assign out_load = (state_r == pabq_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    scan_idx_nxt = scan_idx_r;
    s1_vld_nxt   = 1'b0;
    s2_vld_nxt   = s1_vld_r && pabq_pkg::eligible(s1_idx_r, mode);
    case (state_r)
      pabq_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            pabq_pkg::CMD_WRITE: state_nxt = pabq_pkg::ST_DONE;
            pabq_pkg::CMD_PICK:  state_nxt = pabq_pkg::ST_DONE;
            pabq_pkg::CMD_IDX:   state_nxt = pabq_pkg::ST_RD1;
            default:             state_nxt = pabq_pkg::ST_MIX;
          endcase
          ch_nxt = pabq_pkg::CH_RED;
        end
      end
      pabq_pkg::ST_RD1: begin
        state_nxt = pabq_pkg::ST_RD2;
      end
      pabq_pkg::ST_RD2: begin
        state_nxt = pabq_pkg::ST_MIX;
      end
      pabq_pkg::ST_MIX: begin
        ch_nxt = ch_r + 1'b1;
        if (ch_r == pabq_pkg::CH_BLUE) begin
          state_nxt    = pabq_pkg::ST_SCAN;
          scan_idx_nxt = '0;
        end
      end
      pabq_pkg::ST_SCAN: begin
        s1_vld_nxt   = 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == pabq_pkg::IDX_LAST) begin
          state_nxt = pabq_pkg::ST_DRAIN;
        end
      end
      pabq_pkg::ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = pabq_pkg::ST_KEEP;
        end
      end
      pabq_pkg::ST_KEEP: begin
        state_nxt = pabq_pkg::ST_DONE;
      end
      pabq_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = pabq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pabq_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pabq_pkg::ST_IDLE;
      ch_r        <= pabq_pkg::CH_RED;
      scan_idx_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      scan_idx_r  <= scan_idx_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand capture and blend, one channel per cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r   <= q_item;
      res_r   <= q_item.idx_a;
      blend_r <= (q_item.cmd != pabq_pkg::CMD_WRITE);
      c1_r    <= q_item.c1;
      c2_r    <= q_item.c2;
    end
    if (state_r == pabq_pkg::ST_RD1) begin
      c1_r <= rd_rgb;
    end
    if (state_r == pabq_pkg::ST_RD2) begin
      c2_r <= rd_rgb;
    end
    if (state_r == pabq_pkg::ST_MIX) begin
      case (ch_r)
        pabq_pkg::CH_RED:   mix_r.r <= pabq_pkg::mix8(cur_r.alpha, c1_r.r, c2_r.r);
        pabq_pkg::CH_GREEN: mix_r.g <= pabq_pkg::mix8(cur_r.alpha, c1_r.g, c2_r.g);
        default:            mix_r.b <= pabq_pkg::mix8(cur_r.alpha, c1_r.b, c2_r.b);
      endcase
    end
    if (state_r == pabq_pkg::ST_KEEP) begin
      res_r <= keep ? cur_r.idx_b : pick_r;
    end
  end

  // scan stage one: index beside the memory read
  always_ff @(posedge clk) begin
    s1_idx_r <= scan_idx_r;
  end

  // scan stage two: channel squares
  always_ff @(posedge clk) begin
    s2_idx_r <= s1_idx_r;
    s2_rgb_r <= rd_rgb;
    sq_r_r   <= pabq_pkg::sq_diff(rd_rgb.r, mix_r.r);
    sq_g_r   <= pabq_pkg::sq_diff(rd_rgb.g, mix_r.g);
    sq_b_r   <= pabq_pkg::sq_diff(rd_rgb.b, mix_r.b);
  end

  // scan stage three: sum and keep the strict minimum
  assign dist_sum = {2'b00, sq_r_r} + {2'b00, sq_g_r} + {2'b00, sq_b_r};

  always_ff @(posedge clk) begin
    if (state_r == pabq_pkg::ST_MIX) begin
      best_r <= '1;
    end else if (s2_vld_r && (dist_sum < best_r)) begin
      best_r     <= dist_sum;
      pick_r     <= s2_idx_r;
      pick_rgb_r <= s2_rgb_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= res_r;
      out_blend_r <= blend_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;
  assign out_is_blend    = out_blend_r;

endmodule

`default_nettype wire
